/* rtl/cmpm_pkg.sv */
package cmpm_pkg;

  localparam int unsigned MARKER_W = 32;
  localparam int unsigned STATUS_W = 2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Match request from the load logic to the walker.
  typedef struct packed {
    logic                start;
    logic [STATUS_W-1:0] status;
  } walk_cmd_t;

  // Finished match handed from the walker to the output register.
  typedef struct packed {
    logic                done;
    logic                matched;
    logic [STATUS_W-1:0] status;
  } walk_res_t;

endpackage

/* rtl/cmpm_store.sv */
module cmpm_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [cmpm_pkg::MARKER_W-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [cmpm_pkg::MARKER_W-1:0] rdata_o
);

  logic [cmpm_pkg::MARKER_W-1:0] mem_q [DEPTH];
  logic [cmpm_pkg::MARKER_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/cmpm_walker.sv */
module cmpm_walker #(
  parameter int unsigned AW = 4,
  parameter int unsigned LW = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmpm_pkg::walk_cmd_t           cmd_i,
  input  logic [LW-1:0]                 pat_len_i,
  input  logic [LW-1:0]                 tst_len_i,
  input  logic                          out_free_i,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 pat_addr_o,
  output logic [AW-1:0]                 tst_addr_o,
  input  logic [cmpm_pkg::MARKER_W-1:0] pat_data_i,
  input  logic [cmpm_pkg::MARKER_W-1:0] tst_data_i,
  output cmpm_pkg::walk_res_t           res_o,
  output logic                          busy_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [AW-1:0]                 s_q, s_d;
  logic [AW-1:0]                 p_q, p_d;
  logic [AW-1:0]                 t_q, t_d;
  logic                          matched_q, matched_d;
  logic [cmpm_pkg::STATUS_W-1:0] status_q, status_d;

  logic [LW-1:0] p_inc, t_inc, s_inc;
  logic [AW-1:0] p_nxt, t_nxt;
  logic          eq;

  // One shared compare and index step per visited position pair.
  assign eq    = (pat_data_i == tst_data_i);
  assign p_inc = LW'(p_q) + LW'(1);
  assign t_inc = LW'(t_q) + LW'(1);
  assign s_inc = LW'(s_q) + LW'(1);
  assign p_nxt = (p_inc == pat_len_i) ? '0 : p_inc[AW-1:0];
  assign t_nxt = (t_inc == tst_len_i) ? '0 : t_inc[AW-1:0];

  always_comb begin
    state_d   = state_q;
    s_d       = s_q;
    p_d       = p_q;
    t_d       = t_q;
    matched_d = matched_q;
    status_d  = status_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.start) begin
          status_d  = cmd_i.status;
          matched_d = 1'b0;
          s_d       = '0;
          p_d       = '0;
          t_d       = '0;
          if (cmd_i.status == cmpm_pkg::STATUS_EMPTY) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!eq) begin
          if (s_inc == pat_len_i) begin
            state_d = ST_DONE;
          end else begin
            s_d     = s_inc[AW-1:0];
            p_d     = s_inc[AW-1:0];
            t_d     = '0;
            state_d = ST_RD;
          end
        end else if (p_nxt == s_q && t_nxt == '0) begin
          matched_d = 1'b1;
          state_d   = ST_DONE;
        end else begin
          p_d     = p_nxt;
          t_d     = t_nxt;
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    p_q       <= p_d;
    t_q       <= t_d;
    matched_q <= matched_d;
    status_q  <= status_d;
  end

  assign rd_en_o       = (state_q == ST_RD);
  assign pat_addr_o    = p_q;
  assign tst_addr_o    = t_q;
  assign res_o.done    = (state_q == ST_DONE) && out_free_i;
  assign res_o.matched = matched_q;
  assign res_o.status  = status_q;
  assign busy_o        = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($past(state_q) == ST_RD))
    else $error("compare without a preceding read");

  a_match_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && res_o.matched) |-> (res_o.status != cmpm_pkg::STATUS_EMPTY))
    else $error("match reported on an empty list");
`endif

endmodule

/* rtl/cyclic_marker_pattern_match.sv */
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata tlast     tdata[31:0] marker_id, tuser cmd, tlast last
//                tuser
// m_axis    out  tvalid tready tdata           tdata[0] matched, tdata[2:1] status
//
// A loading item is taken whenever the walker is idle. The item that closes the test list
// starts a walk over both marker memories, unless a list is empty; each compared position
// pair takes one memory read and then one compare, and tready stays low meanwhile.
// Reset clears lengths and the overflow flag, sets the restart bits and resets the state
// machines and the output valid flag; the stores are not cleared. A result waits in the
// output register while new loading items are taken; a finished walk holds in its done
// state until that register is free.
module cyclic_marker_pattern_match #(
  parameter int unsigned MAX_MARKERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] marker_id
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] cmd: 0 pattern list, 1 test list
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] matched, [2:1] status, [7:3] zero
);

  localparam int unsigned AW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int unsigned LW = $clog2(MAX_MARKERS + 1);

  // List bookkeeping.
  logic [LW-1:0] pat_len_q, pat_len_d;
  logic [LW-1:0] tst_len_q, tst_len_d;
  logic          pat_restart_q, pat_restart_d;
  logic          tst_restart_q, tst_restart_d;
  logic          ovf_q, ovf_d;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic                          out_matched_q;
  logic [cmpm_pkg::STATUS_W-1:0] out_status_q;

  logic          accept, to_test, start, out_free, busy;
  logic [LW-1:0] pat_base, tst_base;
  logic          pat_room, tst_room, pat_we, tst_we, drop, ovf_next;
  logic          rd_en;
  logic [AW-1:0] pat_raddr, tst_raddr;
  logic [cmpm_pkg::MARKER_W-1:0] pat_rdata, tst_rdata;
  cmpm_pkg::walk_cmd_t walk_cmd;
  cmpm_pkg::walk_res_t walk_res;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign to_test = s_axis_tuser;

  // An item that opens a new list sees length zero; a full list drops the item.
  assign pat_base = pat_restart_q ? '0 : pat_len_q;
  assign tst_base = tst_restart_q ? '0 : tst_len_q;
  assign pat_room = (pat_base < LW'(MAX_MARKERS));
  assign tst_room = (tst_base < LW'(MAX_MARKERS));
  assign pat_we   = accept && !to_test && pat_room;
  assign tst_we   = accept && to_test && tst_room;
  assign drop     = accept && (to_test ? !tst_room : !pat_room);
  assign ovf_next = ovf_q || drop;
  assign start    = accept && to_test && s_axis_tlast;

  always_comb begin
    pat_len_d     = pat_len_q;
    tst_len_d     = tst_len_q;
    pat_restart_d = pat_restart_q;
    tst_restart_d = tst_restart_q;
    ovf_d         = ovf_q;
    if (accept) begin
      if (!to_test) begin
        pat_len_d     = pat_room ? (pat_base + LW'(1)) : pat_base;
        pat_restart_d = s_axis_tlast;
      end else begin
        tst_len_d     = tst_room ? (tst_base + LW'(1)) : tst_base;
        tst_restart_d = s_axis_tlast;
      end
      // Closing the test list reports and clears any overflow since the last result.
      ovf_d = start ? 1'b0 : ovf_next;
    end
  end

  // Empty wins over overflow; lengths are taken as they stand after this item.
  always_comb begin
    walk_cmd.start = start;
    if (pat_len_q == '0 || tst_len_d == '0) begin
      walk_cmd.status = cmpm_pkg::STATUS_EMPTY;
    end else if (ovf_next) begin
      walk_cmd.status = cmpm_pkg::STATUS_OVERFLOW;
    end else begin
      walk_cmd.status = cmpm_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q     <= '0;
      tst_len_q     <= '0;
      pat_restart_q <= 1'b1;
      tst_restart_q <= 1'b1;
      ovf_q         <= 1'b0;
    end else begin
      pat_len_q     <= pat_len_d;
      tst_len_q     <= tst_len_d;
      pat_restart_q <= pat_restart_d;
      tst_restart_q <= tst_restart_d;
      ovf_q         <= ovf_d;
    end
  end

  cmpm_store #(
    .DEPTH (MAX_MARKERS),
    .AW    (AW)
  ) u_pat_store (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_base[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  cmpm_store #(
    .DEPTH (MAX_MARKERS),
    .AW    (AW)
  ) u_tst_store (
    .clk_i   (clk_i),
    .we_i    (tst_we),
    .waddr_i (tst_base[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (tst_raddr),
    .rdata_o (tst_rdata)
  );

  cmpm_walker #(
    .AW (AW),
    .LW (LW)
  ) u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (walk_cmd),
    .pat_len_i  (pat_len_q),
    .tst_len_i  (tst_len_q),
    .out_free_i (out_free),
    .rd_en_o    (rd_en),
    .pat_addr_o (pat_raddr),
    .tst_addr_o (tst_raddr),
    .pat_data_i (pat_rdata),
    .tst_data_i (tst_rdata),
    .res_o      (walk_res),
    .busy_o     (busy)
  );

  // The output register frees up in the same cycle its item is taken.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (walk_res.done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_res.done) begin
      out_matched_q <= walk_res.matched;
      out_status_q  <= walk_res.status;
    end
  end

  assign s_axis_tready = !busy;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_status_q, out_matched_q};

`ifndef ASSERT_OFF
  a_busy_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast) |=> !s_axis_tready)
    else $error("input not stalled after the test list closed");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_len_q <= LW'(MAX_MARKERS)) && (tst_len_q <= LW'(MAX_MARKERS)))
    else $error("list length beyond store depth");

  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy))
    else $error("result appeared without a finished walk");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the cyclic marker pattern match block.
// Marker items are streamed in over the slave side: a short directed run first, then
// random load episodes and a little noise. A scoreboard keeps its own copy of both marker
// lists and predicts one verdict for every item that closes a test list. Verdicts that come
// out of the master side are checked in order against those predictions.
module tb_top;

  localparam int unsigned MAX_MARKERS = 16;
  localparam int unsigned TARGET_ITEMS = 1200;

  // List selector carried in tuser.
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEST    = 1'b1;

  typedef struct packed {
    logic                          matched;
    logic [cmpm_pkg::STATUS_W-1:0] status;
  } verdict_t;

  // Tracks both marker lists and the verdicts still owed by the block.
  class match_scoreboard;
    logic [31:0] mem [2][MAX_MARKERS];
    int unsigned len [2];
    bit          fresh [2];
    bit          dropped;
    verdict_t    verdicts_due [$];
    int unsigned mismatches;

    function new();
      len[CMD_PATTERN]   = 0;
      len[CMD_TEST]      = 0;
      fresh[CMD_PATTERN] = 1'b1;
      fresh[CMD_TEST]    = 1'b1;
      dropped            = 1'b0;
      mismatches         = 0;
    endfunction

    // True if the test list matches the pattern rotated to start at the given position,
    // walking both lists until each is back at its own start.
    function bit walk_holds(int unsigned start);
      int unsigned p;
      int unsigned t;
      p = start;
      t = 0;
      do begin
        if (mem[CMD_PATTERN][p] != mem[CMD_TEST][t]) return 1'b0;
        p = (p + 1 == len[CMD_PATTERN]) ? 0 : p + 1;
        t = (t + 1 == len[CMD_TEST]) ? 0 : t + 1;
      end while (p != start || t != 0);
      return 1'b1;
    endfunction

    function void note_marker(logic cmd, logic [31:0] marker, logic last);
      verdict_t    v;
      int unsigned s;
      if (fresh[cmd]) begin
        len[cmd]   = 0;
        fresh[cmd] = 1'b0;
      end
      // A full list drops the marker, but a closing flag still closes it.
      if (len[cmd] < MAX_MARKERS) begin
        mem[cmd][len[cmd]] = marker;
        len[cmd]++;
      end else begin
        dropped = 1'b1;
      end
      if (last) fresh[cmd] = 1'b1;
      if (cmd != CMD_TEST || !last) return;

      v.matched = 1'b0;
      if (len[CMD_PATTERN] == 0 || len[CMD_TEST] == 0) begin
        v.status = cmpm_pkg::STATUS_EMPTY;
      end else begin
        for (s = 0; s < len[CMD_PATTERN]; s++) begin
          if (mem[CMD_PATTERN][s] == mem[CMD_TEST][0] && walk_holds(s)) begin
            v.matched = 1'b1;
            break;
          end
        end
        v.status = dropped ? cmpm_pkg::STATUS_OVERFLOW : cmpm_pkg::STATUS_OK;
      end
      dropped = 1'b0;
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(logic [7:0] data);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual matched %0b status %0d",
                 $time, data[0], data[2:1]);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (data[0] !== want.matched) begin
        $display("%0t: matched mismatch, expected %0b, actual %0b",
                 $time, want.matched, data[0]);
        mismatches++;
      end
      if (data[2:1] !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, data[2:1]);
        mismatches++;
      end
    endfunction

    function int unsigned owed();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] marker_id
  logic        s_axis_tlast;
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] matched, [2:1] status, [7:3] zero

  match_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     markers_sent;

  cyclic_marker_pattern_match #(
    .MAX_MARKERS(MAX_MARKERS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 0;
  end

  // Both handshakes are sampled at the rising edge, inputs before results so that a
  // prediction is always in place before its verdict could show up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_marker(s_axis_tuser, s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_verdict(m_axis_tdata);
      end
    end
  end

  // The receiver switches between stall styles: always ready, coin flips, mostly stalled,
  // and long stalls now and then.
  initial begin
    int mode;
    int hold;
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      hold = $urandom_range(40, 300);
      repeat (hold) begin
        @(posedge clk_i);
        case (mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
              stall_left = $urandom_range(5, 25);
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Sends one marker item. The sender works in bursts; a gap of idle cycles may come
  // before a new burst. Returns right after the edge that accepted the item.
  task automatic send_marker(input logic cmd, input logic [31:0] marker, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= marker;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    markers_sent++;
  endtask

  // Holds the sender off until every owed verdict has come back.
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.owed() != 0);
  endtask

  // One load episode: usually a closed pattern list and then a test list. The test list is
  // often a rotation of the pattern, possibly repeated or with one marker spoiled, so that
  // matches are frequent. Some episodes leave the pattern open, skip it, run past the store
  // depth, or end with a few random items.
  task automatic run_episode();
    logic [31:0] abc [3];
    logic [31:0] pat [20];
    logic [31:0] m;
    int          n_abc;
    int          n_pat;
    int          n_tst;
    int          shape;
    int          rot;
    int          bad;
    int          i;
    bit          wide;
    for (i = 0; i < 3; i++) abc[i] = $urandom;
    n_abc = $urandom_range(1, 3);
    wide  = ($urandom_range(0, 9) == 0);
    n_pat = wide ? $urandom_range(1, 19) : $urandom_range(1, 6);
    shape = $urandom_range(0, 9);

    if (shape != 0) begin
      for (i = 0; i < n_pat; i++) begin
        pat[i] = ($urandom_range(0, 7) == 0) ? $urandom : abc[$urandom_range(0, n_abc - 1)];
        send_marker(CMD_PATTERN, pat[i], (shape != 1) && (i == n_pat - 1));
      end
    end

    if (shape >= 1 && shape <= 5) begin
      rot   = $urandom_range(0, n_pat - 1);
      n_tst = n_pat * $urandom_range(1, 3);
      if (n_tst > 19) n_tst = n_pat;
    end else begin
      n_tst = wide ? $urandom_range(1, 19) : $urandom_range(1, 6);
    end
    bad = $urandom_range(0, n_tst - 1);
    for (i = 0; i < n_tst; i++) begin
      if (shape >= 1 && shape <= 5) begin
        m = pat[(rot + i) % n_pat];
        if (shape == 5 && i == bad) m = $urandom;
      end else begin
        m = abc[$urandom_range(0, n_abc - 1)];
      end
      send_marker(CMD_TEST, m, i == n_tst - 1);
    end

    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        send_marker(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int i;
    int episodes;
    sb           = new();
    burst_left   = 0;
    markers_sent = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= CMD_PATTERN;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Closing a test list before any pattern was loaded reports an empty list.
    send_marker(CMD_TEST, 32'hFFFF_FFFF, 1'b1);

    // Seventeen pattern items: the last is dropped but still closes the list, so the next
    // verdict carries the overflow status while the match runs on the first sixteen.
    for (i = 0; i < 17; i++) begin
      send_marker(CMD_PATTERN, (i == 16) ? 32'hFFFF_FFFF : 32'h0000_0000, i == 16);
    end
    send_marker(CMD_TEST, 32'h0000_0000, 1'b1);

    // A pattern list that is still open is matched with what it holds so far, and the
    // overflow flag has been cleared by the previous verdict.
    send_marker(CMD_PATTERN, 32'hA5A5_5A5A, 1'b0);
    send_marker(CMD_PATTERN, 32'hA5A5_5A5A, 1'b0);
    send_marker(CMD_TEST, 32'hA5A5_5A5A, 1'b1);

    // The open list grows by one and closes; the test list is a rotation of it.
    send_marker(CMD_PATTERN, 32'h3C3C_C3C3, 1'b1);
    send_marker(CMD_TEST, 32'h3C3C_C3C3, 1'b0);
    send_marker(CMD_TEST, 32'hA5A5_5A5A, 1'b0);
    send_marker(CMD_TEST, 32'hA5A5_5A5A, 1'b1);
    drain_verdicts();

    episodes = 0;
    while (markers_sent < TARGET_ITEMS) begin
      run_episode();
      episodes++;
      if (episodes % 25 == 0) drain_verdicts();
    end

    drain_verdicts();
    // Give a stray verdict the chance to show up.
    repeat (300) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("PASS cyclic_marker_pattern_match");
    end else begin
      $display("FAIL cyclic_marker_pattern_match");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run: every item closing a test list with
  // the longest possible walk over full stores.
  initial begin
    #500_000_000;
    $display("FAIL cyclic_marker_pattern_match");
    $finish;
  end

endmodule

/* files.f */
rtl/cmpm_pkg.sv
rtl/cmpm_store.sv
rtl/cmpm_walker.sv
rtl/cyclic_marker_pattern_match.sv
sim/tb_top.sv
